// ===== hdl/olist_pkg.sv =====
// Shared types and constants for the ordered list engine.
// No dependencies; imported by every module under hdl.
package olist_pkg;

	localparam int DEPTH = 64;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int IW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int PW    = 6;
	localparam int PCW   = (CW > PW) ? CW : PW;
	localparam int GRP   = 8;
	localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
	localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int PADW  = NGRP * GRP;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_SEARCH = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_INSERT = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_APPEND,
		OP_DELETE,
		OP_INSERT,
		OP_SEARCH
	} cell_op_t;

	typedef struct packed {
		req_type_t          req_type;
		logic signed [31:0] value;
		logic [5:0]         position;
	} req_word_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] found_index;
		logic [6:0] length;
	} rsp_word_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t       op;
		logic [31:0]    value;
		logic [PCW-1:0] pos;
		logic [PCW-1:0] count;
	} cell_cmd_t;

	typedef struct packed {
		logic          done;
		logic          hit;
		logic [IW-1:0] idx;
	} scan_res_t;

endpackage

// ===== hdl/ordered_list_engine_unit.sv =====
// Ordered list engine: a row of DEPTH cells with a shared command broadcast.
// Append, delete and insert pass their result word through the output
// register; a search result follows when the match scan ends, which
// examines 8 cells a cycle. Throughput: one non-search word a cycle while
// the hold slot is empty; a search occupies the block until its scan ends.
// Reset clears the length and control; entries stay undefined, no clear pass.
module ordered_list_engine_unit import olist_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word
);

	// list length and sequencer
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_n;
	state_t        state_q;
	state_t        state_n;

	// result register plus one hold slot, so a word can be taken while the
	// previous result still waits downstream
	rsp_word_t out_q;
	logic      out_valid_q;
	rsp_word_t hold_q;
	logic      hold_valid_q;

	logic      accept;
	logic      take;
	cell_cmd_t cmd;
	rsp_word_t res;
	logic      res_vld;
	logic      imm_vld;
	rsp_word_t imm;
	scan_res_t scan;

	logic [31:0]      ent [DEPTH];
	logic [DEPTH-1:0] match;
	logic [PCW-1:0]   posx;
	logic [PCW-1:0]   cntx;
	logic             full;

	assign req_stall = (state_q != S_IDLE) | hold_valid_q;
	assign accept    = req_valid & ~req_stall;
	assign take      = out_valid_q & ~rsp_stall;

	assign posx = PCW'(req_word.position);
	assign cntx = PCW'(count_q);
	assign full = (count_q == CW'(DEPTH));

	// decode: per-request status, new length and cell command
	always_comb begin
		count_n         = count_q;
		cmd.op          = OP_NOP;
		cmd.value       = req_word.value;
		cmd.pos         = posx;
		cmd.count       = cntx;
		imm_vld         = 1'b0;
		imm.status      = STAT_DONE;
		imm.found_index = '0;
		state_n         = state_q;
		if (accept) begin
			imm_vld = 1'b1;
			case (req_word.req_type)
				REQ_APPEND: begin
					if (full) begin
						imm.status = STAT_FULL;
					end else begin
						cmd.op  = OP_APPEND;
						count_n = count_q + 1'b1;
					end
				end
				REQ_SEARCH: begin
					cmd.op  = OP_SEARCH;
					imm_vld = 1'b0;
					state_n = S_SCAN;
				end
				REQ_DELETE: begin
					if (posx >= cntx) begin
						imm.status = STAT_MISS;
					end else begin
						cmd.op  = OP_DELETE;
						count_n = count_q - 1'b1;
					end
				end
				REQ_INSERT: begin
					if (posx >= cntx) begin
						imm.status = STAT_MISS;
					end else if (full) begin
						imm.status = STAT_FULL;
					end else begin
						cmd.op  = OP_INSERT;
						count_n = count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_SCAN && scan.done) begin
			state_n = S_IDLE;
		end
		imm.length = 7'(count_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
		end
	end

	// the cell row; each cell sees its neighbours' entries for shifting
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] left_e;
		logic [31:0] right_e;
		if (i == 0) begin : g_first
			assign left_e = '0;
		end else begin : g_mid_l
			assign left_e = ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = ent[i+1];
		end
		olist_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.cell_idx    (PCW'(i)),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (ent[i]),
			.hit         (match[i])
		);
	end

	olist_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && req_word.req_type == REQ_SEARCH),
		.match  (match),
		.res    (scan)
	);

	// result select: immediate word, or the scan outcome
	always_comb begin
		if (scan.done) begin
			res_vld         = 1'b1;
			res.status      = scan.hit ? STAT_DONE : STAT_MISS;
			res.found_index = scan.hit ? 6'(scan.idx) : 6'd0;
			res.length      = 7'(count_q);
		end else begin
			res_vld = imm_vld;
			res     = imm;
		end
	end

	// output register with one-word hold slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= hold_valid_q | res_vld;
			hold_valid_q <= hold_valid_q & res_vld;
		end else if (res_vld) begin
			hold_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_q <= hold_valid_q ? hold_q : res;
			if (hold_valid_q && res_vld) begin
				hold_q <= res;
			end
		end else if (res_vld) begin
			hold_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_q;

endmodule

// ===== hdl/olist_cell.sv =====
// One list slot: holds an entry and its search-match flag.
// Depends on olist_pkg.
module olist_cell import olist_pkg::*; (
	input  logic           clk,
	input  cell_cmd_t      cmd,
	input  logic [PCW-1:0] cell_idx,
	input  logic [31:0]    left_entry,
	input  logic [31:0]    right_entry,
	output logic [31:0]    entry,
	output logic           hit
);

	logic [31:0] entry_q;
	logic        hit_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_APPEND: begin
				if (cell_idx == cmd.count) begin
					entry_q <= cmd.value;
				end
			end
			OP_DELETE: begin
				if (cell_idx >= cmd.pos) begin
					entry_q <= right_entry;
				end
			end
			OP_INSERT: begin
				if (cell_idx == cmd.pos) begin
					entry_q <= cmd.value;
				end else if (cell_idx > cmd.pos) begin
					entry_q <= left_entry;
				end
			end
			OP_SEARCH: begin
				hit_q <= (entry_q == cmd.value) && (cell_idx < cmd.count);
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

// ===== hdl/olist_scan.sv =====
// Walks the cells' match flags one group of GRP a cycle, first hit wins.
// Depends on olist_pkg.
module olist_scan import olist_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEPTH-1:0] match,
	output scan_res_t        res
);

	logic          busy_q;
	logic [GW-1:0] grp_q;
	logic [PADW-1:0] match_pad;
	logic [GRP-1:0]  slice;
	logic            any;
	logic [$clog2(GRP)-1:0] first;
	logic            last;

	assign match_pad = PADW'(match);
	assign slice     = match_pad[grp_q * GRP +: GRP];
	assign last      = (grp_q == GW'(NGRP - 1));

	always_comb begin
		any   = |slice;
		first = '0;
		for (int k = GRP - 1; k >= 0; k--) begin
			if (slice[k]) begin
				first = ($clog2(GRP))'(k);
			end
		end
	end

	always_comb begin
		res.done = busy_q & (any | last);
		res.hit  = busy_q & any;
		res.idx  = IW'({grp_q, first});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			grp_q  <= '0;
		end else if (busy_q) begin
			if (any || last) begin
				busy_q <= 1'b0;
			end else begin
				grp_q <= grp_q + 1'b1;
			end
		end
	end

endmodule
